// ===== rtl/rtcep_pkg.sv =====
// Package for the clock-chip digits to epoch seconds converter: types, codes and tables.
package rtcep_pkg;

  // Width of the day count and number of serial multiply steps
  localparam int unsigned DaysW = 16;

  // Days from 1970-01-01 to 1980-01-01 (two leap years in between)
  localparam logic [DaysW-1:0] YearBaseDays = DaysW'(3652);

  // Seconds in one day, the serial multiplicand
  localparam logic [31:0] SecsPerDay = 32'd86400;

  // Status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoClock = 2'd1;
  localparam logic [1:0] StatusRange   = 2'd2;

  // Failing field codes
  localparam logic [2:0] FieldSec   = 3'd0;
  localparam logic [2:0] FieldMin   = 3'd1;
  localparam logic [2:0] FieldHour  = 3'd2;
  localparam logic [2:0] FieldDay   = 3'd3;
  localparam logic [2:0] FieldMonth = 3'd4;
  localparam logic [2:0] FieldYear  = 3'd5;

  // Digit nibble that marks an absent clock chip
  localparam logic [3:0] NoClockDigit = 4'd15;

  // One transfer on the input channel
  typedef struct packed {
    logic [3:0] sec_ones;
    logic [3:0] sec_tens;
    logic [3:0] min_ones;
    logic [3:0] min_tens;
    logic [3:0] hour_ones;
    logic [3:0] hour_tens;
    logic [3:0] day_ones;
    logic [3:0] day_tens;
    logic [3:0] month_ones;
    logic [3:0] month_tens;
    logic [3:0] year_ones;
    logic [3:0] year_tens;
  } rtcep_in_t;

  // One transfer on the output channel
  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [1:0]  status;
    logic [2:0]  bad_field;
  } rtcep_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPrep = 4'b0010,
    StMul  = 4'b0100,
    StDone = 4'b1000
  } rtcep_state_e;

  // ones + 10 * tens; at most 165
  function automatic logic [7:0] pair_value(input logic [3:0] ones, input logic [3:0] tens);
    logic [7:0] t8;
    t8 = {4'b0, tens};
    return {4'b0, ones} + (t8 << 3) + (t8 << 1);
  endfunction

  // Days in the whole months before a month, indexed from 0 (January)
  function automatic logic [8:0] month_cum(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rtc_digits_to_epoch_seconds.sv =====
// Top level: converts clock-chip digit nibbles to seconds since 1970 with a bit-serial multiply.
//
// Usage: one input transfer carries the twelve BCD-style digit nibbles read from the
// clock chip; one output transfer returns the epoch seconds with a status and, on a
// range failure, the code of the first failing field (year, month, day, hour, minute,
// second checked in that order). A seconds-ones nibble of 15 reports that no clock
// chip is fitted. On any error the seconds are zero.
// Both channels use valid/stall; a transfer happens when valid is high and stall low.
// Flow: an input transfer enters one preparation step, then the 16 steps of the
// bit-serial day x 86400 multiply, then a done step that loads the output register;
// on an error, preparation goes straight to done. A new item is taken only when the
// sequencer is idle again, so it waits for the 16-step multiply loop to finish.
// The output register parts the two sides: a new item is taken while a result still
// waits; if the receiver stalls, the finished next result holds in the sequencer until
// the output register frees.
// Reset (asynchronous, active low) empties the sequencer and the output register.
module rtc_digits_to_epoch_seconds (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtcep_pkg::rtcep_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtcep_pkg::rtcep_out_t out_data_o
);
  import rtcep_pkg::*;

  localparam int unsigned CntW = $clog2(DaysW);

  rtcep_state_e state_q, state_d;

  logic [7:0] sec_q, min_q, hour_q, day_q, mon_q, year_q;
  logic       noclk_q;

  logic [DaysW-1:0] days_q, days_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      mcand_q, mcand_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       status_q, status_d;
  logic [2:0]       bad_q, bad_d;

  logic       out_valid_q;
  rtcep_out_t out_q;

  logic in_xfer, out_xfer, out_free;

  logic [DaysW-1:0] days_calc;
  logic [16:0]      hms_calc;
  logic [1:0]       chk_status;
  logic [2:0]       chk_bad;
  logic             feb_leap;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Capture the combined digit pairs on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sec_q   <= pair_value(in_data_i.sec_ones, in_data_i.sec_tens);
      min_q   <= pair_value(in_data_i.min_ones, in_data_i.min_tens);
      hour_q  <= pair_value(in_data_i.hour_ones, in_data_i.hour_tens);
      day_q   <= pair_value(in_data_i.day_ones, in_data_i.day_tens);
      mon_q   <= pair_value(in_data_i.month_ones, in_data_i.month_tens);
      year_q  <= pair_value(in_data_i.year_ones, in_data_i.year_tens);
      noclk_q <= (in_data_i.sec_ones == NoClockDigit);
    end
  end

  // Range checks, first failure wins
  always_comb begin
    chk_status = StatusRange;
    chk_bad    = FieldSec;
    priority if (noclk_q) begin
      chk_status = StatusNoClock;
    end else if (year_q > 8'd99) begin
      chk_bad = FieldYear;
    end else if (mon_q == 8'd0 || mon_q > 8'd12) begin
      chk_bad = FieldMonth;
    end else if (day_q == 8'd0 || day_q > 8'd31) begin
      chk_bad = FieldDay;
    end else if (hour_q > 8'd23) begin
      chk_bad = FieldHour;
    end else if (min_q > 8'd59) begin
      chk_bad = FieldMin;
    end else if (sec_q > 8'd59) begin
      chk_bad = FieldSec;
    end else begin
      chk_status = StatusOk;
    end
  end

  // Day count: whole years, whole months, days of this month; only used when checks pass
  assign feb_leap  = (mon_q > 8'd2) && (year_q[1:0] == 2'b00);
  assign days_calc = YearBaseDays
                   + DaysW'(year_q[6:0]) * DaysW'(365)
                   + DaysW'((year_q[6:0] + 7'd3) >> 2)
                   + DaysW'(month_cum(mon_q[3:0] - 4'd1))
                   + DaysW'(feb_leap)
                   + DaysW'(day_q[4:0]) - DaysW'(1);

  // Seconds within the day
  assign hms_calc = 17'(hour_q[4:0]) * 17'd3600
                  + 17'(min_q[5:0]) * 17'd60
                  + 17'(sec_q[5:0]);

  // Sequencer and serial multiply
  always_comb begin
    state_d  = state_q;
    days_d   = days_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    bad_d    = bad_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        status_d = chk_status;
        bad_d    = (chk_status == StatusRange) ? chk_bad : FieldSec;
        days_d   = days_calc;
        mcand_d  = SecsPerDay;
        cnt_d    = '0;
        if (chk_status == StatusOk) begin
          acc_d   = 32'(hms_calc);
          state_d = StMul;
        end else begin
          acc_d   = '0;
          state_d = StDone;
        end
      end
      StMul: begin
        // one multiplier bit per cycle
        if (days_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        days_d  = days_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DaysW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q   <= days_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    bad_q    <= bad_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_q.epoch_seconds <= acc_q;
      out_q.status        <= status_q;
      out_q.bad_field     <= bad_q;
    end
  end

  // Checks
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == StPrep)
    else $error("accepted item did not enter preparation");

  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul && cnt_q == CntW'(DaysW - 1)) |=> state_q == StDone)
    else $error("multiply loop did not finish after the last bit");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StatusOk) |-> out_data_o.epoch_seconds == 32'd0)
    else $error("error result carries nonzero seconds");

  a_bad_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StatusRange) |-> out_data_o.bad_field == FieldSec)
    else $error("field code set without a range error");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(state_q == StDone && state_d == StIdle))
    else $error("sequencer left done while output register was held");

endmodule

// ===== tb/rtc_digits_to_epoch_seconds_checker.sv =====
// Checker for the digits-to-epoch converter: watches both channels, predicts results and compares.
module rtc_digits_to_epoch_seconds_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  rtcep_pkg::rtcep_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  rtcep_pkg::rtcep_out_t out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  import rtcep_pkg::*;

  rtcep_out_t epoch_q[$];
  rtcep_out_t want;
  int         result_no;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    result_no    = 0;
  end

  // Days in month k, k = 0 for January, ignoring leap years
  function automatic int unsigned month_length(input int unsigned k);
    int unsigned n;
    case (k)
      1:           n = 28;
      3, 5, 8, 10: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic int unsigned digit_pair(input logic [3:0] ones, input logic [3:0] tens);
    return int'(ones) + 10 * int'(tens);
  endfunction

  // Expected output for one reading of the clock chip
  function automatic rtcep_out_t epoch_of_digits(input rtcep_in_t d);
    rtcep_out_t       r;
    int unsigned      yr, mo, dy, hr, mi, se, y, k;
    longint unsigned  days, secs;
    r = '0;
    yr = digit_pair(d.year_ones, d.year_tens);
    mo = digit_pair(d.month_ones, d.month_tens);
    dy = digit_pair(d.day_ones, d.day_tens);
    hr = digit_pair(d.hour_ones, d.hour_tens);
    mi = digit_pair(d.min_ones, d.min_tens);
    se = digit_pair(d.sec_ones, d.sec_tens);
    if (d.sec_ones == NoClockDigit) begin
      r.status = StatusNoClock;
    end else if (yr > 99) begin
      r.status = StatusRange;
      r.bad_field = FieldYear;
    end else if (mo < 1 || mo > 12) begin
      r.status = StatusRange;
      r.bad_field = FieldMonth;
    end else if (dy < 1 || dy > 31) begin
      r.status = StatusRange;
      r.bad_field = FieldDay;
    end else if (hr > 23) begin
      r.status = StatusRange;
      r.bad_field = FieldHour;
    end else if (mi > 59) begin
      r.status = StatusRange;
      r.bad_field = FieldMin;
    end else if (se > 59) begin
      r.status = StatusRange;
      r.bad_field = FieldSec;
    end else begin
      // whole years since 1970, every fourth one a leap year
      days = 0;
      for (y = 70; y < 80 + yr; y++) days += (y % 4 == 0) ? 366 : 365;
      // whole months of this year; the day is not held to its month's length
      for (k = 0; k + 1 < mo; k++) begin
        days += month_length(k);
        if (k == 1 && yr % 4 == 0) days += 1;
      end
      days += dy - 1;
      secs = ((days * 24 + hr) * 60 + mi) * 60 + se;
      r.status = StatusOk;
      r.epoch_seconds = secs[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    $display("result %0d: %s: got %0d, expected %0d", result_no, what, got, exp_val);
    fail_count_o++;
  endtask

  // Sampled mid-cycle: values here are the ones seen at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) epoch_q.push_back(epoch_of_digits(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (epoch_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_data_i.epoch_seconds, 0);
        end else begin
          want = epoch_q.pop_front();
          if (out_data_i.epoch_seconds !== want.epoch_seconds)
            report_mismatch("epoch_seconds", out_data_i.epoch_seconds, want.epoch_seconds);
          if (out_data_i.status !== want.status)
            report_mismatch("status", out_data_i.status, want.status);
          if (out_data_i.bad_field !== want.bad_field)
            report_mismatch("bad_field", out_data_i.bad_field, want.bad_field);
        end
        result_no++;
      end
    end
    pending_o = epoch_q.size();
  end

endmodule

// ===== tb/tb_rtc_digits_to_epoch_seconds.sv =====
// Testbench top for the digits-to-epoch converter: clock, reset, stimulus, stalls and verdict.
module tb_rtc_digits_to_epoch_seconds;
  import rtcep_pkg::*;

  localparam int RandomReadings = 1950;
  localparam int IdleLimit      = 2000;
  localparam int DrainCycles    = 40;

  typedef enum int {StallNone, StallLight, StallHeavy, StallRuns} stall_mode_e;
  typedef enum int {ReadGood, ReadOneBad, ReadNoClock, ReadNoise} reading_kind_e;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  rtcep_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rtcep_out_t out_data;
  int         fail_count;
  int         pending;

  int          idle_cycles = 0;
  int          burst_left  = 0;
  stall_mode_e stall_mode  = StallNone;
  int          mode_left   = 0;
  int          run_left    = 0;
  bit          run_stalled = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rtc_digits_to_epoch_seconds dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rtc_digits_to_epoch_seconds_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Split a value 0..165 into {tens, ones}; scrambled picks a random legal
  // pair, which often puts a ones nibble above nine
  function automatic logic [7:0] split_digits(input int unsigned v, input bit scrambled);
    int unsigned hi, lo, t;
    hi = (v / 10 > 15) ? 15 : v / 10;
    lo = (v > 15) ? (v - 6) / 10 : 0;
    t  = scrambled ? $urandom_range(hi, lo) : hi;
    return {4'(t), 4'(v - 10 * t)};
  endfunction

  function automatic rtcep_in_t make_reading(input int unsigned yr, input int unsigned mo,
                                             input int unsigned dy, input int unsigned hr,
                                             input int unsigned mi, input int unsigned se,
                                             input bit scrambled);
    rtcep_in_t r;
    {r.year_tens, r.year_ones}   = split_digits(yr, scrambled);
    {r.month_tens, r.month_ones} = split_digits(mo, scrambled);
    {r.day_tens, r.day_ones}     = split_digits(dy, scrambled);
    {r.hour_tens, r.hour_ones}   = split_digits(hr, scrambled);
    {r.min_tens, r.min_ones}     = split_digits(mi, scrambled);
    {r.sec_tens, r.sec_ones}     = split_digits(se, scrambled);
    return r;
  endfunction

  // One input transfer, inside bursts of random length with random gaps
  task automatic send_reading(input rtcep_in_t d);
    int gap;
    bit stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= d;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
  endtask

  // Random reading: mostly well-formed dates, then single bad fields,
  // missing clock and raw noise
  task automatic send_random_reading();
    reading_kind_e kind;
    rtcep_in_t     r;
    logic [2:0]    f;
    int unsigned   yr, mo, dy, hr, mi, se, pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 70) ? ReadGood : (pick < 85) ? ReadOneBad :
           (pick < 92) ? ReadNoClock : ReadNoise;
    yr = $urandom_range(0, 99);
    mo = $urandom_range(1, 12);
    dy = $urandom_range(1, 31);
    hr = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    se = $urandom_range(0, 59);
    if (kind == ReadOneBad) begin
      f = 3'($urandom_range(0, 5));
      case (f)
        FieldYear:  yr = $urandom_range(100, 165);
        FieldMonth: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 165);
        FieldDay:   dy = $urandom_range(0, 1) ? 0 : $urandom_range(32, 165);
        FieldHour:  hr = $urandom_range(24, 165);
        FieldMin:   mi = $urandom_range(60, 165);
        default:    se = $urandom_range(60, 165);
      endcase
    end
    r = make_reading(yr, mo, dy, hr, mi, se, 1'($urandom_range(0, 1)));
    if (kind == ReadNoClock) r.sec_ones = NoClockDigit;
    if (kind == ReadNoise) r = rtcep_in_t'(48'({$urandom(), $urandom()}));
    send_reading(r);
  endtask

  // Receiver stall pattern: changes mode every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 200);
    end
    mode_left--;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left = run_stalled ? $urandom_range(1, 40) : $urandom_range(1, 10);
        end
        run_left--;
        out_stall <= run_stalled;
      end
    endcase
  end

  // Watchdog on cycles with no transfer on either channel
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("rtc_digits_to_epoch_seconds regression: fail");
      $finish;
    end
  end

  initial begin
    rtcep_in_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: date extremes, leap handling, overflowing days
    send_reading(make_reading(0, 1, 1, 0, 0, 0, 1'b0));
    send_reading(make_reading(99, 12, 31, 23, 59, 59, 1'b0));
    send_reading(make_reading(0, 2, 29, 12, 30, 30, 1'b0));
    send_reading(make_reading(0, 3, 1, 0, 0, 0, 1'b0));
    send_reading(make_reading(1, 3, 1, 0, 0, 0, 1'b0));
    send_reading(make_reading(1, 2, 31, 6, 7, 8, 1'b0));
    send_reading(make_reading(4, 2, 31, 6, 7, 8, 1'b0));
    send_reading(make_reading(3, 12, 31, 23, 59, 59, 1'b0));
    send_reading(make_reading(4, 1, 1, 0, 0, 0, 1'b0));
    // no clock chip, alone and alongside broken fields
    r = make_reading(20, 6, 15, 10, 20, 30, 1'b0);
    r.sec_ones = NoClockDigit;
    send_reading(r);
    send_reading('1);
    // all nibbles 15 but seconds-ones 14: year 165 fails first
    r = '1;
    r.sec_ones = 4'd14;
    send_reading(r);
    send_reading('0);
    // each field just out of range, and order of checking
    send_reading(make_reading(100, 1, 1, 0, 0, 0, 1'b0));
    send_reading(make_reading(5, 13, 1, 0, 0, 0, 1'b0));
    send_reading(make_reading(5, 0, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(5, 7, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(5, 7, 32, 0, 0, 0, 1'b0));
    send_reading(make_reading(5, 7, 8, 24, 99, 0, 1'b0));
    send_reading(make_reading(5, 7, 8, 9, 60, 0, 1'b0));
    send_reading(make_reading(5, 7, 8, 9, 10, 60, 1'b0));
    send_reading(make_reading(5, 7, 8, 9, 10, 150, 1'b0));
    // ones digits above nine that still combine to a legal value
    r = make_reading(42, 12, 25, 19, 14, 12, 1'b0);
    {r.sec_tens, r.sec_ones}     = {4'd0, 4'd12};
    {r.month_tens, r.month_ones} = {4'd0, 4'd12};
    {r.day_tens, r.day_ones}     = {4'd1, 4'd15};
    {r.min_tens, r.min_ones}     = {4'd0, 4'd14};
    send_reading(r);

    repeat (RandomReadings) send_random_reading();
    in_valid <= 1'b0;

    // Drain, then allow for any stray late result
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rtc_digits_to_epoch_seconds regression: pass");
    end else begin
      $display("rtc_digits_to_epoch_seconds regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rtcep_pkg.sv
rtl/rtc_digits_to_epoch_seconds.sv
tb/rtc_digits_to_epoch_seconds_checker.sv
tb/tb_rtc_digits_to_epoch_seconds.sv
